// ===== design/lifo_pkg.sv =====
// shared types and constants of the lifo stack with indexed access
package lifo_pkg;

  // default sizes of the element store
  localparam int DEPTH_DEF     = 1024;
  localparam int ELEM_W_DEF    = 64;
  localparam int MAX_POP_DEF   = 64;

  // fixed field widths of the stream words
  localparam int MODE_W        = 3;
  localparam int DATA_W        = 64;
  localparam int POS_W         = 10;
  localparam int REQ_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int LEVEL_W       = 11;
  localparam int CAP_W         = 11;

  // input tdata: data_in, position, pop_count, zero pad to whole bytes
  localparam int IN_DATA_LSB   = 0;
  localparam int IN_POS_LSB    = IN_DATA_LSB + DATA_W;
  localparam int IN_REQ_LSB    = IN_POS_LSB + POS_W;
  localparam int IN_TDATA_W    = ((IN_REQ_LSB + REQ_W + 7) / 8) * 8;

  // output tdata: data_out, level, zero pad to whole bytes
  localparam int OUT_TDATA_W   = ((DATA_W + LEVEL_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - DATA_W - LEVEL_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    ModePush   = 3'd0,
    ModePop    = 3'd1,
    ModeRead   = 3'd2,
    ModeWrite  = 3'd3,
    ModeFlush  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    StatOk     = 2'd0,
    StatEmpty  = 2'd1,
    StatRange  = 2'd2,
    StatFull   = 2'd3
  } status_e;

  typedef enum logic {
    StIdle,
    StPop
  } state_e;

endpackage

// ===== design/lifo_stack_with_indexed_access.sv =====
// lifo stack with indexed access: element memory, top pointer and pop sequencer
//
// usage
//   s_axis_* carries one command word per handshake: push, pop of up to
//   pop_count elements, indexed read, indexed write or flush (tuser = mode).
//   m_axis_* returns result words; tlast marks the final word of a command.
//   cfg_* writes capacity_limit; the user must do so only while the block is
//   idle, the block itself does not enforce it. cfg_ready_o is always high.
// pipeline
//   a result word passes the read stage, which waits for the synchronous
//   memory read, and then the output register before it shows on m_axis.
//   push, indexed read, indexed write and flush may follow back to back
//   while the output is not stalled. a pop of n elements reads one element
//   per cycle through the single memory read port while the read stage can
//   move on; the next command is taken after the last element read has been
//   issued. commands with an unused mode are taken and give no word.
// reset
//   the stack is empty and capacity_limit is 1024; the memory itself is not
//   cleared, entries at or above the top are never read.
// stall
//   while m_axis_tready is low the output register holds its word, the read
//   stage holds one more, and once both are full s_axis_tready drops until they can move.
module lifo_stack_with_indexed_access #(
  parameter int DEPTH         = lifo_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = lifo_pkg::ELEM_W_DEF,
  parameter int MAX_POP       = lifo_pkg::MAX_POP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] data_in, [73:64] position, [80:74] pop_count, [87:81] zero
  input  logic [lifo_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] mode
  input  logic [lifo_pkg::MODE_W-1:0]       s_axis_tuser,
  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] data_out, [74:64] level, [79:75] zero
  output logic [lifo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [lifo_pkg::STATUS_W-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  // capacity limit write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lifo_pkg::CAP_W-1:0]        cfg_data_i
);

  localparam int AddrW   = $clog2(DEPTH);
  localparam int PtrW    = $clog2(DEPTH + 1);
  localparam int CntW    = $clog2(MAX_POP + 1);
  localparam int DataW   = lifo_pkg::DATA_W;
  localparam int PosW    = lifo_pkg::POS_W;
  localparam int ReqW    = lifo_pkg::REQ_W;
  localparam int LevelW  = lifo_pkg::LEVEL_W;
  localparam int CapW    = lifo_pkg::CAP_W;
  // compare widths wide enough for both operands
  localparam int PosCmpW = (PtrW > PosW) ? PtrW : PosW;
  localparam int CapCmpW = (PtrW > CapW) ? PtrW : CapW;
  localparam int ReqCmpW = (PtrW > ReqW) ? PtrW : ReqW;

  // unpacked command fields
  logic [DataW-1:0]        in_data;
  logic [PosW-1:0]         in_pos;
  logic [ReqW-1:0]         in_req;
  lifo_pkg::mode_e         in_mode;

  assign in_data = s_axis_tdata[lifo_pkg::IN_DATA_LSB +: DataW];
  assign in_pos  = s_axis_tdata[lifo_pkg::IN_POS_LSB +: PosW];
  assign in_req  = s_axis_tdata[lifo_pkg::IN_REQ_LSB +: ReqW];
  assign in_mode = lifo_pkg::mode_e'(s_axis_tuser);

  // control state
  lifo_pkg::state_e        state_q, state_d;
  logic [PtrW-1:0]         top_q, top_d;
  logic [CntW-1:0]         rem_q, rem_d;
  logic [CapW-1:0]         cap_q;

  // element memory
  logic [ELEMENT_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEMENT_WIDTH-1:0] rdata_q;
  logic                     wr_en, rd_en;
  logic [AddrW-1:0]         waddr, raddr;

  // read stage: result waiting for the memory read data
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_mem_q, s1_mem_d;
  lifo_pkg::status_e        s1_status_q, s1_status_d;
  logic [LevelW-1:0]        s1_level_q, s1_level_d;
  logic                     s1_last_q, s1_last_d;
  logic                     s1_load;

  // output register
  logic                     out_valid_q;
  logic [DataW-1:0]         out_data_q;
  lifo_pkg::status_e        out_status_q;
  logic [LevelW-1:0]        out_level_q;
  logic                     out_last_q;

  logic                     out_free, s1_move, issue_ok, accept;
  logic [PtrW-1:0]          top_m1;
  logic                     pos_oob, full;
  logic [CapCmpW-1:0]       limit;
  logic [ReqW-1:0]          req_c;
  logic [CntW-1:0]          pop_n;

  assign cfg_ready_o = 1'b1;

  assign out_free = !out_valid_q || m_axis_tready;
  assign s1_move  = s1_valid_q && out_free;
  // a new read may start when the read stage is empty or moving on
  assign issue_ok = !s1_valid_q || out_free;
  assign s_axis_tready = (state_q == lifo_pkg::StIdle) && issue_ok;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign top_m1   = top_q - PtrW'(1);
  assign pos_oob  = (PosCmpW'(in_pos) >= PosCmpW'(top_q)) ||
                    (PosCmpW'(in_pos) >= PosCmpW'(DEPTH));
  assign limit    = (CapCmpW'(cap_q) < CapCmpW'(DEPTH)) ? CapCmpW'(cap_q)
                                                        : CapCmpW'(DEPTH);
  assign full     = CapCmpW'(top_q) >= limit;

  // pop request: zero means one, clamp to the largest run
  always_comb begin
    if (in_req == '0) begin
      req_c = ReqW'(1);
    end else if (in_req > ReqW'(MAX_POP)) begin
      req_c = ReqW'(MAX_POP);
    end else begin
      req_c = in_req;
    end
  end

  // run length bounded by the stored count
  assign pop_n = (ReqCmpW'(req_c) < ReqCmpW'(top_q)) ? CntW'(req_c) : CntW'(top_q);

  // command decode and pop sequencer
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    rem_d       = rem_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    waddr       = AddrW'(top_q);
    raddr       = AddrW'(top_m1);
    s1_load     = 1'b0;
    s1_mem_d    = 1'b0;
    s1_status_d = lifo_pkg::StatOk;
    s1_level_d  = LevelW'(top_q);
    s1_last_d   = 1'b1;

    case (state_q)
      lifo_pkg::StIdle: begin
        if (accept) begin
          case (in_mode)
            lifo_pkg::ModePush: begin
              s1_load = 1'b1;
              if (full) begin
                s1_status_d = lifo_pkg::StatFull;
              end else begin
                wr_en      = 1'b1;
                top_d      = top_q + PtrW'(1);
                s1_level_d = LevelW'(top_q + PtrW'(1));
              end
            end
            lifo_pkg::ModePop: begin
              s1_load = 1'b1;
              if (top_q == '0) begin
                s1_status_d = lifo_pkg::StatEmpty;
              end else begin
                // first element of the run goes out right away
                rd_en      = 1'b1;
                s1_mem_d   = 1'b1;
                top_d      = top_m1;
                s1_level_d = LevelW'(top_m1);
                s1_last_d  = (pop_n == CntW'(1));
                rem_d      = pop_n - CntW'(1);
                if (pop_n != CntW'(1)) begin
                  state_d = lifo_pkg::StPop;
                end
              end
            end
            lifo_pkg::ModeRead: begin
              s1_load = 1'b1;
              if (pos_oob) begin
                s1_status_d = lifo_pkg::StatRange;
              end else begin
                rd_en    = 1'b1;
                raddr    = AddrW'(in_pos);
                s1_mem_d = 1'b1;
              end
            end
            lifo_pkg::ModeWrite: begin
              s1_load = 1'b1;
              waddr   = AddrW'(in_pos);
              if (pos_oob) begin
                s1_status_d = lifo_pkg::StatRange;
              end else begin
                wr_en = 1'b1;
              end
            end
            lifo_pkg::ModeFlush: begin
              s1_load    = 1'b1;
              top_d      = '0;
              s1_level_d = '0;
            end
            default: begin
              // unused modes: word taken, nothing happens
            end
          endcase
        end
      end
      lifo_pkg::StPop: begin
        if (issue_ok) begin
          rd_en      = 1'b1;
          s1_load    = 1'b1;
          s1_mem_d   = 1'b1;
          top_d      = top_m1;
          s1_level_d = LevelW'(top_m1);
          s1_last_d  = (rem_q == CntW'(1));
          rem_d      = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = lifo_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = lifo_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lifo_pkg::StIdle;
      top_q       <= '0;
      rem_q       <= '0;
      cap_q       <= lifo_pkg::CAP_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      rem_q      <= rem_d;
      s1_valid_q <= s1_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // element memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= in_data[ELEMENT_WIDTH-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // payload of the read stage and the output register
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mem_q    <= s1_mem_d;
      s1_status_q <= s1_status_d;
      s1_level_q  <= s1_level_d;
      s1_last_q   <= s1_last_d;
    end
    if (s1_move) begin
      out_data_q   <= s1_mem_q ? DataW'(rdata_q) : '0;
      out_status_q <= s1_status_q;
      out_level_q  <= s1_level_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{lifo_pkg::OUT_PAD_W{1'b0}}, out_level_q, out_data_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // stack never holds more than the memory depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(top_q) <= PtrW'(DEPTH))
    else $error("top pointer beyond memory depth");

  // no new command while a pop run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lifo_pkg::StPop) |-> !s_axis_tready)
    else $error("command taken during pop run");

  // each pop step removes exactly one element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lifo_pkg::StPop && issue_ok) |=> (top_q == $past(top_m1)))
    else $error("pop step did not decrement top");

  // read stage never overwritten while it still waits on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |-> !s1_load)
    else $error("read stage overrun");

endmodule

// ===== bench/lifo_stack_with_indexed_access_test.sv =====
// testbench for the lifo stack with indexed access: random and directed commands, scoreboard
`timescale 1ns / 100ps

module lifo_stack_with_indexed_access_test;

  localparam int          STACK_DEPTH = lifo_pkg::DEPTH_DEF;
  localparam int          POP_MAX     = lifo_pkg::MAX_POP_DEF;
  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int          IDLE_PCT    = 37;
  // cycles to let a result-free command leave the pipe before a register write
  localparam int          SETTLE      = 8;

  // one result word as the block should return it
  typedef struct {
    logic [lifo_pkg::DATA_W-1:0]  data;
    lifo_pkg::status_e            status;
    logic [lifo_pkg::LEVEL_W-1:0] level;
    logic                         last;
  } stack_word_t;

  // mirror of the stack contents, top pointer and capacity limit; holds the
  // words still owed by the block, oldest first
  class lifo_mirror;
    logic [lifo_pkg::DATA_W-1:0] elems [STACK_DEPTH];
    int unsigned       top;
    int unsigned       cap_limit;
    stack_word_t       pending_words[$];
    int unsigned       mismatches;
    int unsigned       words_seen;
    int unsigned       mode_seen[8];

    function new();
      top       = 0;
      cap_limit = 1024;
    endfunction

    function void owe(logic [lifo_pkg::DATA_W-1:0] data, lifo_pkg::status_e status,
                      logic last);
      stack_word_t w;
      w.data   = data;
      w.status = status;
      w.level  = lifo_pkg::LEVEL_W'(top);
      w.last   = last;
      pending_words.push_back(w);
    endfunction

    // apply one accepted command and queue the words it must produce
    function void take_command(logic [lifo_pkg::MODE_W-1:0] mode,
                               logic [lifo_pkg::DATA_W-1:0] data,
                               logic [lifo_pkg::POS_W-1:0] pos,
                               logic [lifo_pkg::REQ_W-1:0] req);
      int unsigned lim;
      int unsigned n;
      lim = (cap_limit < STACK_DEPTH) ? cap_limit : STACK_DEPTH;
      mode_seen[mode]++;
      case (mode)
        lifo_pkg::ModePush: begin
          if (top >= lim) begin
            owe('0, lifo_pkg::StatFull, 1'b1);
          end else begin
            elems[top] = data;
            top++;
            owe('0, lifo_pkg::StatOk, 1'b1);
          end
        end
        lifo_pkg::ModePop: begin
          if (top == 0) begin
            owe('0, lifo_pkg::StatEmpty, 1'b1);
          end else begin
            n = (req == 0) ? 1 : req;
            if (n > POP_MAX) n = POP_MAX;
            if (n > top) n = top;
            // newest element first, last mark on the final one
            for (int k = 0; k < n; k++) begin
              top--;
              owe(elems[top], lifo_pkg::StatOk, k == n - 1);
            end
          end
        end
        lifo_pkg::ModeRead: begin
          if (pos >= top) owe('0, lifo_pkg::StatRange, 1'b1);
          else owe(elems[pos], lifo_pkg::StatOk, 1'b1);
        end
        lifo_pkg::ModeWrite: begin
          if (pos >= top) begin
            owe('0, lifo_pkg::StatRange, 1'b1);
          end else begin
            elems[pos] = data;
            owe('0, lifo_pkg::StatOk, 1'b1);
          end
        end
        lifo_pkg::ModeFlush: begin
          top = 0;
          owe('0, lifo_pkg::StatOk, 1'b1);
        end
        default: ;  // unused modes give nothing
      endcase
    endfunction

    function void check_word(logic [lifo_pkg::DATA_W-1:0] data,
                             logic [lifo_pkg::STATUS_W-1:0] status,
                             logic [lifo_pkg::LEVEL_W-1:0] level, logic last);
      stack_word_t w;
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d arrived with nothing owed: data %h status %0d level %0d last %0b",
                   words_seen, data, status, level, last);
        return;
      end
      w = pending_words.pop_front();
      if (data !== w.data || status !== w.status || level !== w.level || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d mismatch: expected data %h status %0d level %0d last %0b",
                   words_seen, w.data, w.status, w.level, w.last);
          $display("                  got      data %h status %0d level %0d last %0b",
                   data, status, level, last);
        end
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  // [63:0] data_in, [73:64] position, [80:74] pop_count, [87:81] zero
  logic [lifo_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  // [2:0] mode
  logic [lifo_pkg::MODE_W-1:0]      s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // [63:0] data_out, [74:64] level, [79:75] zero
  logic [lifo_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [lifo_pkg::STATUS_W-1:0]    m_axis_tuser;
  logic                             m_axis_tlast;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [lifo_pkg::CAP_W-1:0]       cfg_data_i;

  lifo_mirror  mirror = new();
  bit          steady;         // no idling on either side while set
  int unsigned cycle_count;
  int unsigned cap_writes;

  lifo_stack_with_indexed_access u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, mirror.pending_words.size());
      $display("lifo_stack_with_indexed_access_test NOT OK");
      $finish;
    end
  end

  // result side: random back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // every word taken at the rising edge goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.check_word(m_axis_tdata[lifo_pkg::DATA_W-1:0], m_axis_tuser,
                        m_axis_tdata[lifo_pkg::DATA_W +: lifo_pkg::LEVEL_W], m_axis_tlast);
  end

  // offer one command word, with random gaps ahead of it, and hold it until taken;
  // tvalid is left high so the next call can follow without a bubble
  task automatic send_command(logic [lifo_pkg::MODE_W-1:0] mode,
                              logic [lifo_pkg::DATA_W-1:0] data,
                              logic [lifo_pkg::POS_W-1:0] pos,
                              logic [lifo_pkg::REQ_W-1:0] req);
    logic [lifo_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[lifo_pkg::IN_DATA_LSB +: lifo_pkg::DATA_W] = data;
    word[lifo_pkg::IN_POS_LSB +: lifo_pkg::POS_W]   = pos;
    word[lifo_pkg::IN_REQ_LSB +: lifo_pkg::REQ_W]   = req;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.take_command(mode, data, pos, req);
  endtask

  // stop offering and wait until every owed word is back and the pipe is quiet
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mirror.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lifo_pkg::CAP_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mirror.cap_limit = value;
    cap_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random command biased toward pushes and in-range indexes;
  // returns 0 for an unused mode, which does not count as work
  task automatic send_random(output bit counted);
    int unsigned pick;
    logic [lifo_pkg::DATA_W-1:0] d;
    logic [lifo_pkg::POS_W-1:0]  p;
    logic [lifo_pkg::REQ_W-1:0]  r;
    pick = $urandom_range(0, 99);
    d = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 1) ? '1 : '0;
    if (mirror.top > 0 && $urandom_range(0, 3) != 0)
      p = lifo_pkg::POS_W'($urandom_range(0, mirror.top - 1));
    else
      p = lifo_pkg::POS_W'($urandom_range(0, STACK_DEPTH - 1));
    r = ($urandom_range(0, 3) == 0) ? lifo_pkg::REQ_W'($urandom_range(0, 127))
                                    : lifo_pkg::REQ_W'($urandom_range(1, 6));
    counted = 1'b1;
    if (pick < 38)      send_command(lifo_pkg::ModePush, d, lifo_pkg::POS_W'($urandom), r);
    else if (pick < 58) send_command(lifo_pkg::ModePop, d, p, r);
    else if (pick < 73) send_command(lifo_pkg::ModeRead, d, p, r);
    else if (pick < 88) send_command(lifo_pkg::ModeWrite, d, p, r);
    else if (pick < 93) send_command(lifo_pkg::ModeFlush, d, p, r);
    else begin
      send_command(lifo_pkg::MODE_W'($urandom_range(5, 7)), d, p, r);
      counted = 1'b0;
    end
  endtask

  initial begin
    logic [lifo_pkg::CAP_W-1:0] phase_caps [6];
    bit                         counted;
    int                         done;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    steady        = 1'b0;
    cycle_count   = 0;
    cap_writes    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty stack errors, data extremes, index edges, pop clamping
    send_command(lifo_pkg::ModePop, '0, '0, 7'd5);            // pop on empty
    send_command(lifo_pkg::ModeRead, '0, 10'd0, '0);          // read with nothing stored
    send_command(lifo_pkg::ModeWrite, '1, 10'd0, '0);         // write with nothing stored
    send_command(lifo_pkg::ModeFlush, '0, '0, '0);            // flush when already empty
    send_command(lifo_pkg::ModePush, '1, '0, '0);
    send_command(lifo_pkg::ModePush, '0, '0, '0);
    send_command(lifo_pkg::ModePush, {32{2'b10}}, '0, '0);
    send_command(lifo_pkg::ModePush, {32{2'b01}}, '0, '0);
    send_command(lifo_pkg::ModeRead, '0, 10'd0, '0);
    send_command(lifo_pkg::ModeRead, '0, 10'd3, '0);          // newest entry
    send_command(lifo_pkg::ModeRead, '0, 10'd4, '0);          // index equal to level
    send_command(lifo_pkg::ModeRead, '0, 10'd1023, '0);       // largest index
    send_command(lifo_pkg::ModeWrite, 64'h0123_4567_89ab_cdef, 10'd1, '0);
    send_command(lifo_pkg::ModeRead, '0, 10'd1, '0);
    send_command(lifo_pkg::ModePop, '0, '0, 7'd0);            // zero count pops one
    send_command(lifo_pkg::ModePop, '0, '0, 7'd127);          // clamped to max, then to level
    send_command(lifo_pkg::MODE_W'(5), '1, '1, '1);           // unused modes
    send_command(lifo_pkg::MODE_W'(6), '0, '0, '0);
    send_command(lifo_pkg::MODE_W'(7), '1, '1, '1);
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModeFlush, '0, '0, '0);
    send_command(lifo_pkg::ModePop, '0, '0, 7'd1);

    // zero capacity: every push is full
    write_capacity(lifo_pkg::CAP_W'(0));
    send_command(lifo_pkg::ModePush, '1, '0, '0);
    send_command(lifo_pkg::ModePop, '0, '0, 7'd1);

    // capacity of one
    write_capacity(lifo_pkg::CAP_W'(1));
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModeRead, '0, 10'd0, '0);
    send_command(lifo_pkg::ModePop, '0, '0, 7'd2);

    // capacity above the store size, then a pop longer than the largest run
    write_capacity('1);
    while (mirror.top < 70)
      send_command(lifo_pkg::ModePush, {$urandom, $urandom}, lifo_pkg::POS_W'($urandom), '0);
    send_command(lifo_pkg::ModeRead, '0, lifo_pkg::POS_W'(mirror.top - 1), '0);
    send_command(lifo_pkg::ModeWrite, '1, lifo_pkg::POS_W'(mirror.top - 1), '0);
    send_command(lifo_pkg::ModeRead, '0, lifo_pkg::POS_W'(mirror.top - 1), '0);
    send_command(lifo_pkg::ModeRead, '0, 10'd1023, '0);       // far beyond the top
    send_command(lifo_pkg::ModePop, '0, '0, 7'd127);          // clamped to the largest run

    // capacity lowered under the stored level: contents stay, pushes refused until pops bring the level below it
    write_capacity(lifo_pkg::CAP_W'(3));
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModeRead, '0, lifo_pkg::POS_W'(mirror.top - 1), '0);
    while (mirror.top >= 3)
      send_command(lifo_pkg::ModePop, '0, '0,
                   lifo_pkg::REQ_W'((mirror.top > 66) ? 64 : mirror.top - 2));
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModePush, {$urandom, $urandom}, '0, '0);
    send_command(lifo_pkg::ModeFlush, '0, '0, '0);

    // random phases across several capacity settings, one without idling
    phase_caps[0] = lifo_pkg::CAP_W'(1024);
    phase_caps[1] = lifo_pkg::CAP_W'(5);
    phase_caps[2] = '1;
    phase_caps[3] = lifo_pkg::CAP_W'(1);
    phase_caps[4] = lifo_pkg::CAP_W'(40);
    phase_caps[5] = lifo_pkg::CAP_W'($urandom_range(1, 1024));
    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      steady = (i == 2);
      done = 0;
      while (done < 36) begin
        send_random(counted);
        if (counted) done++;
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d pushes, %0d pops, %0d reads, %0d writes, %0d flushes",
             mirror.mode_seen[lifo_pkg::ModePush], mirror.mode_seen[lifo_pkg::ModePop],
             mirror.mode_seen[lifo_pkg::ModeRead], mirror.mode_seen[lifo_pkg::ModeWrite],
             mirror.mode_seen[lifo_pkg::ModeFlush]);
    $display("%0d result words, %0d capacity writes incl. zero, one, lowered under level",
             mirror.words_seen, cap_writes);
    if (mirror.mismatches == 0 && mirror.pending_words.size() == 0) begin
      $display("lifo_stack_with_indexed_access_test OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived",
               mirror.mismatches, mirror.pending_words.size());
      $display("lifo_stack_with_indexed_access_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lifo_pkg.sv
design/lifo_stack_with_indexed_access.sv
bench/lifo_stack_with_indexed_access_test.sv
